FILE: design/binary_morphology_border_extract_core_assert.svh
// Assertion shorthands for the border extractor.
`ifndef BINARY_MORPHOLOGY_BORDER_EXTRACT_CORE_ASSERT_SVH
`define BINARY_MORPHOLOGY_BORDER_EXTRACT_CORE_ASSERT_SVH

// Same-cycle implication, switched off while in reset.
`define BMBE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("bmbe: same-cycle check failed");

// Next-cycle implication, switched off while in reset.
`define BMBE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("bmbe: next-cycle check failed");

`endif

FILE: design/bmbe_pkg.sv
`default_nettype none
package bmbe_pkg;

  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 1024;
  localparam int unsigned PixBits   = 16;
  localparam int unsigned ThrBits   = 17;
  localparam int unsigned GeoBits   = 11;
  localparam int unsigned PosBits   = $clog2(MaxWidth > MaxHeight ? MaxWidth : MaxHeight);
  localparam int unsigned AddrBits  = $clog2(MaxWidth);
  localparam int unsigned NStage    = 6;
  localparam int unsigned MemBits   = 3 * NStage;
  localparam int unsigned PendBits  = 13;
  localparam int unsigned PaddrBits = 4;

  localparam logic [GeoBits-1:0] MinGeo    = GeoBits'(3);
  localparam logic [GeoBits-1:0] MaxGeoW   = GeoBits'(MaxWidth);
  localparam logic [GeoBits-1:0] MaxGeoH   = GeoBits'(MaxHeight);
  localparam logic [ThrBits-1:0] ThrReset  = ThrBits'(128);
  localparam logic [GeoBits-1:0] WReset    = GeoBits'(640);
  localparam logic [GeoBits-1:0] HReset    = GeoBits'(480);
  localparam logic [7:0]         BorderOn  = 8'd255;
  localparam logic [7:0]         BorderOff = 8'd0;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_WIDTH     = 2'd1,
    REG_HEIGHT    = 2'd2,
    REG_SPARE     = 2'd3
  } reg_idx_e;

  typedef logic [8:0] win_t;  // bit (dr+1)*3+(dc+1)

  // Which window positions are interior pixels of the frame.
  function automatic win_t interior_mask(input logic [PosBits-1:0] r, input logic [PosBits-1:0] c,
                                         input logic [GeoBits-1:0] w, input logic [GeoBits-1:0] h);
    logic [2:0] rok;
    logic [2:0] cok;
    win_t m;
    rok[0] = r >= PosBits'(2);
    rok[1] = (r != '0) && (({2'b00, r} + 12'd2) <= {1'b0, h});
    rok[2] = ({2'b00, r} + 12'd3) <= {1'b0, h};
    cok[0] = c >= PosBits'(2);
    cok[1] = (c != '0) && (({2'b00, c} + 12'd2) <= {1'b0, w});
    cok[2] = ({2'b00, c} + 12'd3) <= {1'b0, w};
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        m[i*3+j] = rok[i] & cok[j];
      end
    end
    return m;
  endfunction

  // Per-centre flag: any one (or any zero) in the window, own pixel at the edge.
  function automatic logic centre_flag(input win_t win, input logic inner, input logic any_one);
    logic r;
    if (inner) begin
      r = any_one ? (|win) : (|(~win));
    end else begin
      r = any_one ? win[4] : ~win[4];
    end
    return r;
  endfunction

  // Gather flags from interior neighbours plus the pixel's own flag.
  function automatic logic gather_flag(input win_t win, input win_t imask, input logic invert);
    logic acc;
    acc = win[4] | (|(win & imask & 9'b111_101_111));
    return acc ^ invert;
  endfunction

endpackage
`default_nettype wire

FILE: design/bmbe_if.sv
`default_nettype none
interface bmbe_pix_if import bmbe_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [PixBits-1:0] pixel;
  modport source (output valid, kind, pixel, input ready);
  modport sink (input valid, kind, pixel, output ready);
endinterface

interface bmbe_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] border;
  logic       frame_end;
  modport source (output valid, border, frame_end, input ready);
  modport sink (input valid, border, frame_end, output ready);
endinterface
`default_nettype wire

FILE: design/bmbe_line_mem.sv
`default_nettype none
module bmbe_line_mem import bmbe_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [AddrBits-1:0] waddr_i,
  input  wire logic [MemBits-1:0]  wdata_i,
  input  wire logic [AddrBits-1:0] raddr_i,
  output logic      [MemBits-1:0]  rdata_o
);

  logic [MemBits-1:0] mem [MaxWidth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

FILE: design/binary_morphology_border_extract_core.sv
// Binary border extractor: grey pixels in raster order are thresholded (at or
// above the threshold register is foreground), the mask is opened with a 3x3
// square (erosion, then dilation) and each result is opened AND NOT
// eroded(opened), given as 0 or 255 on the border field. One input beat is
// taken per clock; the block accepts a new beat every cycle while the output
// register is empty or being emptied. Results trail the input stream by a fixed
// 6*(width+1) beats, so after the last pixel of a frame send drain beats
// (kind = 1) to push the tail out; drains are dropped in mid-frame or when
// nothing is pending. The last result of a frame carries frame_end. A frame
// may follow the previous one before its tail is drained. All six window
// stages work in the same cycle off one shared line memory (one read and one write
// port, MAX_WIDTH deep) that delays every stage stream by one row; a fill
// count masks entries not yet written, so no clearing pass is needed. Writing
// frame_width or frame_height flushes the pipeline and drops pending results;
// both are clamped to 3..1024. Registers: threshold at 0x0, frame_width at
// 0x4, frame_height at 0x8; write only while idle.
`default_nettype none
`include "binary_morphology_border_extract_core_assert.svh"
module binary_morphology_border_extract_core import bmbe_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  bmbe_pix_if.sink                  pix_i,
  bmbe_res_if.source                res_o,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [PaddrBits-1:0] paddr,
  input  wire logic [31:0]          pwdata,
  output logic      [31:0]          prdata,
  output logic                      pready
);

  // ---------------- configuration registers ----------------
  logic [ThrBits-1:0] threshold_q;
  logic [GeoBits-1:0] width_q, height_q;
  logic [GeoBits-1:0] w_eff, h_eff;
  logic               cfg_wr, flush;
  reg_idx_e           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel & penable & pwrite;
  assign flush   = cfg_wr & ((cfg_idx == REG_WIDTH) | (cfg_idx == REG_HEIGHT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= ThrReset;
      width_q     <= WReset;
      height_q    <= HReset;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_THRESHOLD: threshold_q <= pwdata[ThrBits-1:0];
        REG_WIDTH:     width_q     <= pwdata[GeoBits-1:0];
        REG_HEIGHT:    height_q    <= pwdata[GeoBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_THRESHOLD: prdata = {{(32-ThrBits){1'b0}}, threshold_q};
      REG_WIDTH:     prdata = {{(32-GeoBits){1'b0}}, width_q};
      REG_HEIGHT:    prdata = {{(32-GeoBits){1'b0}}, height_q};
      default:       prdata = '0;
    endcase
  end

  // Clamp geometry to what the line memory supports.
  assign w_eff = (width_q < MinGeo) ? MinGeo : ((width_q > MaxGeoW) ? MaxGeoW : width_q);
  assign h_eff = (height_q < MinGeo) ? MinGeo : ((height_q > MaxGeoH) ? MaxGeoH : height_q);

  // ---------------- input side ----------------
  logic                in_acc, pix_push, drain_push, push;
  logic [PosBits-1:0]  in_row_q, in_col_q;
  logic [PendBits-1:0] pending_q;
  logic                out_valid_q;
  logic                res_valid;

  assign pix_i.ready = ~out_valid_q | res_o.ready;
  assign in_acc      = pix_i.valid & pix_i.ready;
  assign pix_push    = in_acc & ~pix_i.kind;
  // A drain only advances the stream between frames and while results are owed.
  assign drain_push  = in_acc & pix_i.kind & (pending_q != '0) &
                       (in_row_q == '0) & (in_col_q == '0);
  assign push        = pix_push | drain_push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q  <= '0;
      in_col_q  <= '0;
      pending_q <= '0;
    end else if (flush) begin
      in_row_q  <= '0;
      in_col_q  <= '0;
      pending_q <= '0;
    end else begin
      if (pix_push) begin
        if ({1'b0, in_col_q} == w_eff - GeoBits'(1)) begin
          in_col_q <= '0;
          in_row_q <= ({1'b0, in_row_q} == h_eff - GeoBits'(1)) ? '0 : in_row_q + PosBits'(1);
        end else begin
          in_col_q <= in_col_q + PosBits'(1);
        end
      end
      pending_q <= pending_q + PendBits'(pix_push) - PendBits'(res_valid);
    end
  end

  // ---------------- line memory ----------------
  // Entry: [5:0] stage streams, [11:6] the same one row older, [17:12] valid chains.
  logic [AddrBits-1:0] ptr_q, ptr_d;
  logic [GeoBits-1:0]  fill_q;
  logic                primed;
  logic [MemBits-1:0]  rd_data, wr_data;
  logic [NStage-1:0]   b0, c0, vb0;

  always_comb begin
    ptr_d = ptr_q;
    if (flush) begin
      ptr_d = '0;
    end else if (push) begin
      ptr_d = ({1'b0, ptr_q} == w_eff - GeoBits'(1)) ? '0 : ptr_q + AddrBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      fill_q <= '0;
    end else begin
      ptr_q <= ptr_d;
      if (flush) begin
        fill_q <= '0;
      end else if (push && fill_q != w_eff) begin
        fill_q <= fill_q + GeoBits'(1);
      end
    end
  end

  // Entries not yet written since the flush read as zero.
  assign primed = (fill_q == w_eff);
  assign b0     = primed ? rd_data[NStage-1:0] : '0;
  assign c0     = primed ? rd_data[2*NStage-1:NStage] : '0;
  assign vb0    = primed ? rd_data[3*NStage-1:2*NStage] : '0;

  bmbe_line_mem u_line_mem (
    .clk_i  (clk_i),
    .we_i   (push),
    .waddr_i(ptr_q),
    .wdata_i(wr_data),
    .raddr_i(ptr_d),
    .rdata_o(rd_data)
  );

  // ---------------- window taps and stages ----------------
  logic [NStage-1:0]  a1_q, a2_q, b1_q, b2_q, c1_q, c2_q, vb1_q;
  logic [NStage-1:0]  nw, vn, sv;
  logic [PosBits-1:0] row_q [NStage];
  logic [PosBits-1:0] col_q [NStage];
  win_t               win;
  win_t               imask;
  logic               flag;

  // Stage k+1 reads stream k; odd stages flag windows, even stages gather flags.
  always_comb begin
    nw    = '0;
    vn    = '0;
    sv    = '0;
    win   = '0;
    imask = '0;
    flag  = 1'b0;
    nw[0] = ({1'b0, pix_i.pixel} >= threshold_q) & pix_push;
    vn[0] = pix_push;
    for (int k = 0; k < NStage; k++) begin
      win   = {nw[k], a1_q[k], a2_q[k], b0[k], b1_q[k], b2_q[k], c0[k], c1_q[k], c2_q[k]};
      imask = interior_mask(row_q[k], col_q[k], w_eff, h_eff);
      if (k % 2 == 0) begin
        flag = centre_flag(win, imask[4], k == 2);
      end else begin
        flag = gather_flag(win, imask, k != 3);
      end
      sv[k] = vb1_q[k] & flag;
      if (k < NStage - 1) begin
        nw[k+1] = sv[k];
        vn[k+1] = vb1_q[k];
      end
    end
  end

  assign wr_data = {vn, b0, nw};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a1_q  <= '0;
      a2_q  <= '0;
      b1_q  <= '0;
      b2_q  <= '0;
      c1_q  <= '0;
      c2_q  <= '0;
      vb1_q <= '0;
      for (int k = 0; k < NStage; k++) begin
        row_q[k] <= '0;
        col_q[k] <= '0;
      end
    end else if (flush) begin
      a1_q  <= '0;
      a2_q  <= '0;
      b1_q  <= '0;
      b2_q  <= '0;
      c1_q  <= '0;
      c2_q  <= '0;
      vb1_q <= '0;
      for (int k = 0; k < NStage; k++) begin
        row_q[k] <= '0;
        col_q[k] <= '0;
      end
    end else if (push) begin
      a2_q  <= a1_q;
      a1_q  <= nw;
      b2_q  <= b1_q;
      b1_q  <= b0;
      c2_q  <= c1_q;
      c1_q  <= c0;
      vb1_q <= vb0;
      // Advance each stage's centre position over the pixels it has passed.
      for (int k = 0; k < NStage; k++) begin
        if (vb1_q[k]) begin
          if ({1'b0, col_q[k]} == w_eff - GeoBits'(1)) begin
            col_q[k] <= '0;
            row_q[k] <= ({1'b0, row_q[k]} == h_eff - GeoBits'(1)) ? '0
                        : row_q[k] + PosBits'(1);
          end else begin
            col_q[k] <= col_q[k] + PosBits'(1);
          end
        end
      end
    end
  end

  // ---------------- result register ----------------
  logic       opened, last;
  logic [7:0] border_q;
  logic       frame_end_q;

  assign res_valid = push & vb1_q[NStage-1];
  // Opened value of the output pixel is the oldest tap of the stage 4 stream.
  assign opened    = c2_q[4];
  assign last      = ({1'b0, row_q[NStage-1]} == h_eff - GeoBits'(1)) &&
                     ({1'b0, col_q[NStage-1]} == w_eff - GeoBits'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      border_q    <= (opened & ~sv[NStage-1]) ? BorderOn : BorderOff;
      frame_end_q <= last;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.border    = border_q;
  assign res_o.frame_end = frame_end_q;

  // ---------------- checks ----------------
  `BMBE_ASSERT_IMP(a_res_owed, clk_i, rst_ni, res_valid, pending_q != '0)
  `BMBE_ASSERT_NXT(a_out_empties, clk_i, rst_ni, out_valid_q && res_o.ready && !res_valid, !out_valid_q)
  `BMBE_ASSERT_IMP(a_ptr_range, clk_i, rst_ni, 1'b1, {1'b0, ptr_q} < w_eff)
  `BMBE_ASSERT_IMP(a_fill_range, clk_i, rst_ni, 1'b1, fill_q <= w_eff)

endmodule
`default_nettype wire

FILE: verif/binary_morphology_border_extract_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module binary_morphology_border_extract_checker import bmbe_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  bmbe_pix_if                       pix,
  bmbe_res_if                       res,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic                 pready,
  input  wire logic [PaddrBits-1:0] paddr,
  input  wire logic [31:0]          pwdata,
  output int                        fail_count_o,
  output int                        outstanding_o
);

  localparam int RingLen = 8 * MaxWidth + 8;

  typedef struct packed {
    logic [7:0] border;
    logic       frame_end;
  } border_res_t;

  border_res_t border_q[$];

  logic [ThrBits-1:0] thr;
  logic [GeoBits-1:0] fw;
  logic [GeoBits-1:0] fh;

  logic [7:0]  strm_bits [RingLen];
  int unsigned strm_tag  [RingLen];
  int unsigned head;
  int unsigned row_pos;
  int unsigned col_pos;
  int unsigned pend;

  function automatic int unsigned clamp_geo(input logic [GeoBits-1:0] v, input int unsigned hi);
    int unsigned g;
    g = v;
    if (g < 3) g = 3;
    if (g > hi) g = hi;
    return g;
  endfunction

  function automatic void flush_stream();
    for (int i = 0; i < RingLen; i++) begin
      strm_bits[i] = '0;
      strm_tag[i]  = 0;
    end
    head    = 0;
    row_pos = 0;
    col_pos = 0;
    pend    = 0;
  endfunction

  function automatic int unsigned slot_of(input int unsigned off);
    return (head + RingLen - (off % RingLen)) % RingLen;
  endfunction

  function automatic logic bit_of(input int unsigned off, input int unsigned s);
    return strm_bits[slot_of(off)][s];
  endfunction

  // One window stage: odd stages flag per centre, even stages gather flags.
  function automatic logic stage_bit(input int unsigned k, input int unsigned d,
                                     input int r, input int c, input int w, input int h);
    int unsigned src;
    logic inner;
    logic acc;
    logic v;
    src   = k - 1;
    inner = (r >= 1) && (r + 2 <= h) && (c >= 1) && (c + 2 <= w);
    if (k % 2 == 1) begin
      if (!inner) begin
        acc = bit_of(d, src);
        return (k == 3) ? acc : ~acc;
      end
      acc = 1'b0;
      for (int dr = -1; dr <= 1; dr++) begin
        for (int dc = -1; dc <= 1; dc++) begin
          v   = bit_of(int'(d) - dr * w - dc, src);
          acc = acc | ((k == 3) ? v : ~v);
        end
      end
      return acc;
    end
    acc = bit_of(d, src);
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        if (!(dr == 0 && dc == 0) && r + dr >= 1 && r + dr <= h - 2 &&
            c + dc >= 1 && c + dc <= w - 2) begin
          acc = acc | bit_of(int'(d) - dr * w - dc, src);
        end
      end
    end
    return (k == 4) ? acc : ~acc;
  endfunction

  // Advance the stream by one beat; push the expected result, if any.
  function automatic void predict_beat(input logic kind, input logic [PixBits-1:0] pixel);
    int unsigned w;
    int unsigned h;
    int unsigned s;
    int unsigned t;
    int unsigned d;
    logic [7:0] fresh;
    int unsigned fresh_tag;
    logic last;
    logic v;
    border_res_t e;
    w = clamp_geo(fw, MaxWidth);
    h = clamp_geo(fh, MaxHeight);
    fresh = '0;
    fresh_tag = 0;
    if (kind) begin
      if (pend == 0 || row_pos != 0 || col_pos != 0) return;
    end else begin
      last = (row_pos + 1 >= h) && (col_pos + 1 >= w);
      fresh[0] = ({1'b0, pixel} >= thr);
      fresh_tag = 1 | (int'(last) << 1) | ((col_pos & 'h1FFF) << 2) | ((row_pos & 'h1FFF) << 15);
      if (col_pos + 1 >= w) begin
        col_pos = 0;
        row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
      end else begin
        col_pos++;
      end
      pend++;
    end
    head = (head + 1) % RingLen;
    strm_bits[head] = fresh;
    strm_tag[head]  = fresh_tag;
    for (int unsigned k = 1; k <= NStage; k++) begin
      d = k * (w + 1);
      s = slot_of(d);
      t = strm_tag[s];
      v = 1'b0;
      if (t & 1) v = stage_bit(k, d, (t >> 15) & 'h1FFF, (t >> 2) & 'h1FFF, w, h);
      strm_bits[s][k] = v;
    end
    s = slot_of(NStage * (w + 1));
    t = strm_tag[s];
    if (!(t & 1)) return;
    e.border    = (strm_bits[s][4] && !strm_bits[s][6]) ? BorderOn : BorderOff;
    e.frame_end = (t >> 1) & 1;
    border_q.push_back(e);
    if (pend > 0) pend--;
  endfunction

  assign outstanding_o = border_q.size();

  // Sample at the falling edge: every handshake signal is settled by then.
  always @(negedge clk_i) begin
    border_res_t e;
    if (!rst_ni) begin
      fail_count_o = 0;
      thr = ThrReset;
      fw  = WReset;
      fh  = HReset;
      flush_stream();
      border_q.delete();
    end else begin
      if (res.valid && res.ready) begin
        if (border_q.size() == 0) begin
          $display("%0t: result beat with nothing expected: border %0d frame_end %0b",
                   $time, res.border, res.frame_end);
          fail_count_o++;
        end else begin
          e = border_q.pop_front();
          if (res.border !== e.border) begin
            $display("%0t: border expected %0d actual %0d", $time, e.border, res.border);
            fail_count_o++;
          end
          if (res.frame_end !== e.frame_end) begin
            $display("%0t: frame_end expected %0b actual %0b", $time, e.frame_end,
                     res.frame_end);
            fail_count_o++;
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[3:2]))
          REG_THRESHOLD: thr = pwdata[ThrBits-1:0];
          REG_WIDTH: begin
            fw = pwdata[GeoBits-1:0];
            flush_stream();
          end
          REG_HEIGHT: begin
            fh = pwdata[GeoBits-1:0];
            flush_stream();
          end
          default: ;
        endcase
      end
      if (pix.valid && pix.ready) predict_beat(pix.kind, pix.pixel);
    end
  end

endmodule
`default_nettype wire

FILE: verif/binary_morphology_border_extract_core_test.sv
`timescale 1ns / 100ps
`default_nettype none
module binary_morphology_border_extract_core_test;
  import bmbe_pkg::*;

  localparam int CycleLimit = 900000;
  // Receiver hold-off window, in cycles counted from the start of simulation.
  localparam int HoldStart  = 400;
  localparam int HoldCycles = 200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PaddrBits-1:0] paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  int fail_count;
  int outstanding;
  int cyc = 0;
  int idle_pct = 36;   // sender idle chance per beat, dropped to 0 for calm stretches
  int rand_beats = 0;
  int cur_thr = 128;

  bmbe_pix_if pix ();
  bmbe_res_if res ();

  binary_morphology_border_extract_core u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_i   (pix),
    .res_o   (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  binary_morphology_border_extract_checker u_border_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pix           (pix),
    .res           (res),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  always #5 clk_i = ~clk_i;

  // Global watchdog: a hung handshake must not run forever.
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: random stalls, a calm stretch, and one long hold-off so the
  // block fills up and pushes back on its input.
  always @(posedge clk_i) begin
    if (cyc >= HoldStart && cyc < HoldStart + HoldCycles) begin
      res.ready <= 1'b0;
    end else if (cyc >= 1200 && cyc < 1700) begin
      res.ready <= 1'b1;
    end else begin
      res.ready <= ($urandom_range(0, 99) >= 36);
    end
  end

  // Entered just after a rising edge; returns just after the accepting edge.
  task automatic put_beat(input logic k, input logic [PixBits-1:0] p);
    while ($urandom_range(0, 99) < idle_pct) begin
      pix.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix.valid <= 1'b1;
    pix.kind  <= k;
    pix.pixel <= p;
    do @(negedge clk_i); while (!pix.ready);
    @(posedge clk_i);
  endtask

  task automatic apb_write(input reg_idx_e idx, input logic [31:0] val);
    pix.valid <= 1'b0;
    psel      <= 1'b1;
    penable   <= 1'b0;
    pwrite    <= 1'b1;
    paddr     <= PaddrBits'(idx) << 2;
    pwdata    <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready);
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_THRESHOLD) cur_thr = int'(val[ThrBits-1:0]);
    @(posedge clk_i);
  endtask

  // Hold until every expected result is out, then let stray work settle.
  task automatic wait_drained();
    pix.valid <= 1'b0;
    while (outstanding != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic int clamp(input int v, input int hi);
    return (v < 3) ? 3 : ((v > hi) ? hi : v);
  endfunction

  // Grey value on the chosen side of the threshold.
  function automatic logic [PixBits-1:0] grey(input int fg_pct);
    if ($urandom_range(0, 99) < fg_pct) begin
      return (cur_thr > 65535) ? PixBits'($urandom) : PixBits'($urandom_range(cur_thr, 65535));
    end
    return (cur_thr == 0) ? PixBits'($urandom) : PixBits'($urandom_range(0, cur_thr - 1));
  endfunction

  task automatic set_geometry(input int w, input int h);
    if ($urandom_range(0, 1)) begin
      apb_write(REG_WIDTH, w);
      apb_write(REG_HEIGHT, h);
    end else begin
      apb_write(REG_HEIGHT, h);
      apb_write(REG_WIDTH, w);
    end
  endtask

  // One frame of pixels; noise adds stray drains in mid-frame, which are dropped.
  task automatic put_frame(input int w, input int h, input int fg_pct, input bit noise);
    int n;
    n = clamp(w, MaxWidth) * clamp(h, MaxHeight);
    for (int i = 0; i < n; i++) begin
      if (noise && i != 0 && $urandom_range(0, 99) < 4) put_beat(1'b1, PixBits'($urandom));
      put_beat(1'b0, grey(fg_pct));
      rand_beats++;
    end
  endtask

  // Drain beats to push the tail of the last frame out.
  task automatic put_tail(input int w);
    int n;
    n = 6 * (clamp(w, MaxWidth) + 1) + $urandom_range(0, 4);
    for (int i = 0; i < n; i++) begin
      put_beat(1'b1, PixBits'($urandom));
      rand_beats++;
    end
  endtask

  initial begin
    int w;
    int h;
    int nf;
    pix.valid = 1'b0;
    pix.kind  = 1'b0;
    pix.pixel = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Drain with nothing pending: dropped.
    put_beat(1'b1, 16'hFFFF);
    put_beat(1'b1, 16'h0000);
    wait_drained();

    // Smallest frame, all foreground, extreme grey values, stray drain mid-frame.
    apb_write(REG_THRESHOLD, 0);
    set_geometry(3, 3);
    put_beat(1'b0, 16'h0000);
    put_beat(1'b0, 16'hFFFF);
    put_beat(1'b1, 16'hFFFF);
    for (int i = 0; i < 7; i++) put_beat(1'b0, (i % 2) ? 16'hFFFF : 16'h0000);
    // Next frame back to back before the tail is drained.
    for (int i = 0; i < 9; i++) put_beat(1'b0, PixBits'($urandom));
    put_tail(3);
    wait_drained();

    // Threshold above every grey value: empty mask.
    apb_write(REG_THRESHOLD, 65536);
    put_frame(4, 3, 100, 1'b0);
    put_tail(4);
    wait_drained();

    // Wider rows with no sender idling; the receiver hold-off lands in here.
    apb_write(REG_THRESHOLD, 65535);
    set_geometry(32, 3);
    idle_pct = 0;
    put_frame(32, 3, 60, 1'b0);
    put_tail(32);
    idle_pct = 36;
    wait_drained();

    // Out of range geometry clamped at the low end.
    apb_write(REG_THRESHOLD, 32768);
    set_geometry(2, 0);
    put_frame(2, 0, 65, 1'b1);
    put_tail(2);
    wait_drained();

    // Random phases: mostly well-formed frames with random content.
    rand_beats = 0;
    while (rand_beats < 420) begin
      idle_pct = ($urandom_range(0, 4) == 0) ? 0 : 36;
      case ($urandom_range(0, 3))
        0:       apb_write(REG_THRESHOLD, 0);
        1:       apb_write(REG_THRESHOLD, 65536);
        default: apb_write(REG_THRESHOLD, $urandom_range(1, 65535));
      endcase
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
      set_geometry(w, h);
      nf = $urandom_range(1, 3);
      for (int f = 0; f < nf; f++) put_frame(w, h, $urandom_range(20, 90), $urandom_range(0, 1));
      put_tail(w);
      wait_drained();
    end
    idle_pct = 36;

    wait_drained();
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire
